FILE: rtl/ratom_pkg.sv
// Shared types and constants for the relay autotune oscillation meter.
package ratom_pkg;

    localparam int POS_W      = 14;
    localparam int TICK_W     = 32;
    localparam int DRIVE_W    = 15;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int AMP_AVG_W  = POS_W + FRAC_W;
    localparam int PER_AVG_W  = TICK_W + FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_FULL = 14'd10000;

    localparam logic [POS_W-1:0]    THRESHOLD_RST = 14'd6000;
    localparam logic [POS_W-1:0]    AMPLITUDE_RST = 14'd2000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'd3277;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [TICK_W-1:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      cycle_end;
        logic [POS_W-1:0]          avg_amplitude;
        logic [TICK_W-1:0]         avg_period;
    } out_item_t;

    // measurement handed from the tracking stage to the averaging stage
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      closed;
        logic [POS_W-1:0]          amplitude;
        logic [TICK_W-1:0]         period;
    } meas_t;

endpackage

FILE: rtl/ratom_track.sv
// Relay decision, cycle bound tracking and period/amplitude measurement.
module ratom_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ratom_pkg::in_item_t item,
    input  logic [13:0]       threshold,
    input  logic [13:0]       amplitude,
    output ratom_pkg::meas_t  meas
);
    import ratom_pkg::*;

    logic              was_above_reg, was_above_next;
    logic [TICK_W-1:0] start_reg, start_next;
    logic [POS_W-1:0]  min_reg, min_next;
    logic [POS_W-1:0]  max_reg, max_next;

    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  amp;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic              above;
    logic              closed;

    always_comb
    begin
        pos    = (item.position > POS_FULL) ? POS_FULL : item.position;
        amp    = (amplitude > POS_FULL) ? POS_FULL : amplitude;
        above  = pos > threshold;
        closed = !above && was_above_reg;

        meas.closed    = closed;
        meas.period    = item.timestamp - start_reg;
        meas.amplitude = (max_reg >= min_reg) ? (max_reg - min_reg) : '0;
        meas.drive     = above ? -$signed({1'b0, amp}) : $signed({1'b0, amp});

        // crossing sample seeds the new cycle
        lo = closed ? POS_FULL : min_reg;
        hi = closed ? '0 : max_reg;

        was_above_next = above;
        start_next     = closed ? item.timestamp : start_reg;
        min_next       = (pos < lo) ? pos : lo;
        max_next       = (pos > hi) ? pos : hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_above_reg <= 1'b0;
            start_reg     <= '0;
            min_reg       <= POS_FULL;
            max_reg       <= '0;
        end
        else if (advance)
        begin
            was_above_reg <= was_above_next;
            start_reg     <= start_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

endmodule

FILE: rtl/ratom_ema.sv
// Exponential average update: old + round(w * (meas - old)) in Q.16.
module ratom_ema #(
    parameter int W = 30
) (
    input  logic [W-1:0]    old_avg,
    input  logic [W-17:0]   meas,
    input  logic [15:0]     weight,
    output logic [W-1:0]    new_avg
);
    import ratom_pkg::*;

    logic signed [W:0]    diff;
    logic signed [W+17:0] prod;
    logic signed [W+17:0] rounded;

    always_comb
    begin
        diff    = $signed({1'b0, meas, {FRAC_W{1'b0}}}) - $signed({1'b0, old_avg});
        prod    = $signed({1'b0, weight}) * diff;
        rounded = prod + $signed((W+18)'(32768));
        new_avg = old_avg + W'(rounded >>> FRAC_W);
    end

endmodule

FILE: rtl/relay_autotune_oscillation_meter_core.sv
// Relay autotune oscillation meter: relay drive, cycle measurement, averages.
// Path: each input beat passes the input, measure and average registers to the output.
// Throughput: one beat per clock while the output is not stalled; each average update is seen by the next beat.
// Stall on the output holds the full stages; in_stall is derived from it combinationally once all stages are full.
// Reset: config returns to 6000/2000/3277, cycle bounds to 10000/0, averages to 0.
module relay_autotune_oscillation_meter_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ratom_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ratom_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import ratom_pkg::*;

    logic [POS_W-1:0]    thr_reg;
    logic [POS_W-1:0]    amp_reg;
    logic [WEIGHT_W-1:0] wgt_reg;

    logic     i_v_reg;
    in_item_t i_item_reg;
    logic     m_v_reg;
    meas_t    m_meas_reg;
    logic     o_v_reg;
    out_item_t o_item_reg;

    logic [AMP_AVG_W-1:0] amp_avg_reg, amp_avg_next;
    logic [PER_AVG_W-1:0] per_avg_reg, per_avg_next;
    logic [AMP_AVG_W-1:0] amp_blend;
    logic [PER_AVG_W-1:0] per_blend;

    logic  o_ready, m_ready, i_ready;
    logic  m_load, o_load;
    meas_t meas;

    assign o_ready  = !o_v_reg || !out_stall;
    assign m_ready  = !m_v_reg || o_ready;
    assign i_ready  = !i_v_reg || m_ready;
    assign in_stall = !i_ready;
    assign m_load   = i_v_reg && m_ready;
    assign o_load   = m_v_reg && o_ready;

    assign cfg_ready = 1'b1;
    assign out_valid = o_v_reg;
    assign out_data  = o_item_reg;

    ratom_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (m_load),
        .item      (i_item_reg),
        .threshold (thr_reg),
        .amplitude (amp_reg),
        .meas      (meas)
    );

    ratom_ema #(.W(AMP_AVG_W)) u_amp_ema (
        .old_avg (amp_avg_reg),
        .meas    (m_meas_reg.amplitude),
        .weight  (wgt_reg),
        .new_avg (amp_blend)
    );

    ratom_ema #(.W(PER_AVG_W)) u_per_ema (
        .old_avg (per_avg_reg),
        .meas    (m_meas_reg.period),
        .weight  (wgt_reg),
        .new_avg (per_blend)
    );

    assign amp_avg_next = m_meas_reg.closed ? amp_blend : amp_avg_reg;
    assign per_avg_next = m_meas_reg.closed ? per_blend : per_avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            amp_reg <= AMPLITUDE_RST;
            wgt_reg <= WEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data[POS_W-1:0];
                REG_AMPLITUDE: amp_reg <= cfg_data[POS_W-1:0];
                REG_WEIGHT:    wgt_reg <= cfg_data[WEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg     <= 1'b0;
            m_v_reg     <= 1'b0;
            o_v_reg     <= 1'b0;
            amp_avg_reg <= '0;
            per_avg_reg <= '0;
        end
        else
        begin
            if (i_ready)
                i_v_reg <= in_valid;
            if (m_ready)
                m_v_reg <= i_v_reg;
            if (o_ready)
                o_v_reg <= m_v_reg;
            if (o_load)
            begin
                amp_avg_reg <= amp_avg_next;
                per_avg_reg <= per_avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (i_ready && in_valid)
            i_item_reg <= in_data;
        if (m_load)
            m_meas_reg <= meas;
        if (o_load)
        begin
            o_item_reg.drive         <= m_meas_reg.drive;
            o_item_reg.cycle_end     <= m_meas_reg.closed;
            o_item_reg.avg_amplitude <= amp_avg_next[AMP_AVG_W-1:FRAC_W];
            o_item_reg.avg_period    <= per_avg_next[PER_AVG_W-1:FRAC_W];
        end
    end

endmodule

FILE: rtl/ratom_checker.sv
// Port-level checks for the oscillation meter, bound to the top level.
module ratom_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input ratom_pkg::out_item_t out_data
);
    import ratom_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    // a cycle closes only on a sample at or below threshold, so drive is not negative
    a_end_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cycle_end |-> !out_data.drive[DRIVE_W-1])
        else $error("cycle end with negative drive");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.drive >= -15'sd10000) && (out_data.drive <= 15'sd10000))
        else $error("drive out of range");

    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.avg_amplitude <= POS_FULL)
        else $error("amplitude average out of range");

endmodule

bind relay_autotune_oscillation_meter_core ratom_checker u_ratom_checker (.*);
